### rtl/lpbg_pkg.sv
package lpbg_pkg;

    // Field widths
    localparam int PIXEL_BITS  = 11;
    localparam int COORD_W     = 24;
    localparam int COEF_W      = 32;
    localparam int CLASS_W     = 3;
    localparam int COEF_IDX_W  = 4;
    localparam int BIAS_W      = 8;
    localparam int REQ_W       = 2;

    // Projection matrix shape
    localparam int ROWS        = 3;
    localparam int COLS        = 4;
    localparam int NCOEF       = ROWS * COLS;
    localparam int COL_W       = $clog2(COLS);
    localparam int POINT_FRAC  = 8;

    // Datapath widths
    localparam int PROD_W      = COEF_W + COORD_W;           // one coefficient * coordinate
    localparam int ACC_W       = PROD_W + 2;                 // sum of four terms
    localparam int BND_W       = PIXEL_BITS + 2;             // top + bias + height
    localparam int CLO_W       = (PROD_W + 1) / 2;           // low half of c
    localparam int CHI_W       = PROD_W - CLO_W;             // high half of c
    localparam int PP_W        = BND_W + CLO_W;
    localparam int FULL_W      = BND_W + CLO_W + CHI_W;
    localparam int CMP_W       = FULL_W + 1;

    // Box bound slots
    localparam int NBND        = 4;
    localparam int BND_L       = 0;
    localparam int BND_R       = 1;
    localparam int BND_T       = 2;
    localparam int BND_B       = 3;

    // Command queue
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [REQ_W-1:0]   REQ_BOX   = 2'd0;
    localparam logic [REQ_W-1:0]   REQ_POINT = 2'd1;
    localparam logic [REQ_W-1:0]   REQ_COEF  = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_BAD     = 3'd7;

    localparam logic [BIAS_W-1:0]  ROW_BIAS_RESET = 8'd10;

    // Calibration product K*[R|t], Q11.20, row-major
    localparam logic signed [COEF_W-1:0] CALIB [NCOEF] = '{
         32'sd340180904, -32'sd664833440,    32'sd8230170,  32'sd183238623,
         32'sd272041665,    32'sd2407437, -32'sd645379862,  32'sd281835002,
           32'sd1047323,     -32'sd20099,      32'sd47137,     32'sd446522
    };

    typedef enum logic [1:0] {
        CMD_BOX,
        CMD_POINT,
        CMD_COEF
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_X,
        ST_MAC_Y,
        ST_MAC_Z,
        ST_SUM,
        ST_BOUND,
        ST_CMP
    } t_bstate;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                     last_point;
        logic [PIXEL_BITS-1:0]    box_left;
        logic [PIXEL_BITS-1:0]    box_top;
        logic [PIXEL_BITS-1:0]    box_width;
        logic [PIXEL_BITS-1:0]    box_height;
        logic [CLASS_W-1:0]       sign_class;
        logic [COEF_IDX_W-1:0]    coef_index;
        logic signed [COEF_W-1:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
        logic [CLASS_W-1:0]        hit_class;
    } t_out_item;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
        logic [PIXEL_BITS-1:0]     left;
        logic [PIXEL_BITS-1:0]     top;
        logic [PIXEL_BITS-1:0]     width;
        logic [PIXEL_BITS-1:0]     height;
        logic [CLASS_W-1:0]        cls;
        logic [COEF_IDX_W-1:0]     cidx;
        logic signed [COEF_W-1:0]  cval;
    } t_cmd_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        t_bstate state;
        logic    box_valid;
    } t_back_stat;

endpackage

### rtl/lidar_point_bbox_gate.sv
// Lidar point gate against the latest camera detection box. A box update
// (req_type 0) stores left, top, width, height and class; a coefficient write
// (req_type 2) replaces one entry of the 3x4 Q11.20 projection matrix, which
// resets to the calibration product. A point (req_type 1, Q15.8 metres) is
// projected to (a,b,c) exactly and passes when left*c <= a <= (left+width)*c
// and (top+row_bias)*c <= b <= (top+row_bias+height)*c with c > 0. Only the
// first passing point of a frame produces a transfer on the output, echoing
// the point and the stored class; last_point closes the frame. Points give
// nothing until a box has been received. A front end pushes requests into a
// two-entry command queue while it is not full; the back end drains it in
// order. Box and coefficient requests retire in the idle state. A tested
// point is dequeued, then takes three multiply steps through the three row
// lanes (one 32x24 multiplier each), one final sum, one step of bound * c
// partial products and one compare step. Points skipped because the frame
// already matched, or no box is held, are dropped at dequeue. A finished
// result sits in an output register while the back end continues, and the
// queue keeps the input side moving. The user writes row_bias over the cfg
// channel (always ready) only while idle; the block does not enforce it.
module lidar_point_bbox_gate import lpbg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BIAS_W-1:0] i_cfg_data
);

    logic [BIAS_W-1:0] r_row_bias;

    // queue hookup
    logic       push;
    t_cmd_entry push_data;
    logic       pop;
    t_cmd_entry q_head;
    t_q_stat    q_stat;
    t_back_stat back_stat;

    // config register, single entry, no back-pressure
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bias <= ROW_BIAS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_row_bias <= i_cfg_data;
        end
    end

    // classify and filter requests
    lpbg_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decouples front and back
    lpbg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_stat      (q_stat)
    );

    // projection, box test, result register
    lpbg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_q_head    (q_head),
        .o_q_pop     (pop),
        .i_row_bias  (r_row_bias),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_stat      (back_stat)
    );

`ifndef SYNTH
    // never write into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("push into full command queue");

    // a new result only comes out of the compare step
    a_result_from_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(back_stat.state == ST_CMP))
        else $error("result loaded outside compare step");

    // no result without a stored box
    a_result_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> back_stat.box_valid)
        else $error("result produced without a box");
`endif

endmodule

### rtl/lpbg_front.sv
module lpbg_front import lpbg_pkg::*; (
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_cmd_entry o_push_data
);

    logic keep;

    // Always accept unless the queue is full; unknown requests and
    // out-of-range coefficient writes are swallowed here.
    assign o_in_ready = !i_q_stat.full;

    always_comb begin
        keep              = 1'b0;
        o_push_data.cmd   = CMD_POINT;
        o_push_data.x     = i_in_data.point_x;
        o_push_data.y     = i_in_data.point_y;
        o_push_data.z     = i_in_data.point_z;
        o_push_data.last  = i_in_data.last_point;
        o_push_data.left  = i_in_data.box_left;
        o_push_data.top   = i_in_data.box_top;
        o_push_data.width = i_in_data.box_width;
        o_push_data.height = i_in_data.box_height;
        o_push_data.cls   = (i_in_data.sign_class == CLASS_BAD) ? CLASS_UNKNOWN
                                                                : i_in_data.sign_class;
        o_push_data.cidx  = i_in_data.coef_index;
        o_push_data.cval  = i_in_data.coef_value;
        case (i_in_data.req_type)
            REQ_BOX: begin
                keep            = 1'b1;
                o_push_data.cmd = CMD_BOX;
            end
            REQ_POINT: begin
                keep            = 1'b1;
                o_push_data.cmd = CMD_POINT;
            end
            REQ_COEF: begin
                keep            = (i_in_data.coef_index < COEF_IDX_W'(NCOEF));
                o_push_data.cmd = CMD_COEF;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_in_valid && o_in_ready && keep;

endmodule

### rtl/lpbg_queue.sv
module lpbg_queue import lpbg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd_entry i_push_data,
    input  logic       i_pop,
    output t_cmd_entry o_head,
    output t_q_stat    o_stat
);

    t_cmd_entry        r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

### rtl/lpbg_back.sv
module lpbg_back import lpbg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_stat           i_q_stat,
    input  t_cmd_entry        i_q_head,
    output logic              o_q_pop,
    input  logic [BIAS_W-1:0] i_row_bias,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    output t_back_stat        o_stat
);

    t_bstate r_state;
    t_bstate n_state;

    // Box and frame state
    logic                  r_box_valid;
    logic [PIXEL_BITS-1:0] r_left;
    logic [PIXEL_BITS-1:0] r_top;
    logic [PIXEL_BITS-1:0] r_width;
    logic [PIXEL_BITS-1:0] r_height;
    logic [CLASS_W-1:0]    r_class;
    logic                  r_frame_matched;

    logic signed [COEF_W-1:0] r_coef [ROWS][COLS];

    // Point in flight
    logic signed [COORD_W-1:0] r_pt_x;
    logic signed [COORD_W-1:0] r_pt_y;
    logic signed [COORD_W-1:0] r_pt_z;
    logic                      r_pt_last;
    logic [BND_W-1:0]          r_bnd   [NBND];
    logic signed [ACC_W-1:0]   r_acc   [ROWS];
    logic signed [PROD_W-1:0]  r_prod  [ROWS];
    logic [PP_W-1:0]           r_pp_lo [NBND];
    logic [PP_W-1:0]           r_pp_hi [NBND];
    logic                      r_c_pos;

    logic      r_out_valid;
    t_out_item r_out_data;

    // Sequencer outputs
    logic pop;
    logic launch;
    logic out_free;
    logic load_out;
    logic cmp_done;
    logic mac_mul;
    logic mac_add;
    logic do_bound;
    logic [COL_W-1:0]          mac_col;
    logic signed [COORD_W-1:0] mac_coord;

    // Compare
    logic [FULL_W-1:0]       full_p [NBND];
    logic signed [CMP_W-1:0] a_ext;
    logic signed [CMP_W-1:0] b_ext;
    logic                    hit;

    logic [CLO_W-1:0] c_lo;
    logic [CHI_W-1:0] c_hi;

    assign c_lo = r_acc[ROWS-1][CLO_W-1:0];
    assign c_hi = r_acc[ROWS-1][CLO_W+CHI_W-1:CLO_W];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  begin
                if (launch) begin
                    n_state = ST_MAC_X;
                end
            end
            ST_MAC_X: n_state = ST_MAC_Y;
            ST_MAC_Y: n_state = ST_MAC_Z;
            ST_MAC_Z: n_state = ST_SUM;
            ST_SUM:   n_state = ST_BOUND;
            ST_BOUND: n_state = ST_CMP;
            ST_CMP:   begin
                if (cmp_done) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        pop      = (r_state == ST_IDLE) && !i_q_stat.empty;
        launch   = pop && (i_q_head.cmd == CMD_POINT) && r_box_valid && !r_frame_matched;
        out_free = !r_out_valid || i_out_ready;
        load_out = (r_state == ST_CMP) && hit && out_free;
        cmp_done = (r_state == ST_CMP) && (!hit || out_free);
        mac_mul  = r_state inside {ST_MAC_X, ST_MAC_Y, ST_MAC_Z};
        mac_add  = r_state inside {ST_MAC_Y, ST_MAC_Z, ST_SUM};
        do_bound = (r_state == ST_BOUND);
        case (r_state)
            ST_MAC_Y: begin
                mac_col   = COL_W'(1);
                mac_coord = r_pt_y;
            end
            ST_MAC_Z: begin
                mac_col   = COL_W'(2);
                mac_coord = r_pt_z;
            end
            default: begin
                mac_col   = COL_W'(0);
                mac_coord = r_pt_x;
            end
        endcase
    end

    // Exact box test on the cross-multiplied bounds
    always_comb begin
        for (int j = 0; j < NBND; j++) begin
            full_p[j] = (FULL_W'(r_pp_hi[j]) << CLO_W) + FULL_W'(r_pp_lo[j]);
        end
        a_ext = CMP_W'(r_acc[0]);
        b_ext = CMP_W'(r_acc[1]);
        hit   = r_c_pos
             && (a_ext >= $signed({1'b0, full_p[BND_L]}))
             && (a_ext <= $signed({1'b0, full_p[BND_R]}))
             && (b_ext >= $signed({1'b0, full_p[BND_T]}))
             && (b_ext <= $signed({1'b0, full_p[BND_B]}));
    end

    // Control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_box_valid     <= 1'b0;
            r_frame_matched <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < ROWS; i++) begin
                for (int j = 0; j < COLS; j++) begin
                    r_coef[i][j] <= CALIB[i*COLS+j];
                end
            end
        end else begin
            r_state <= n_state;

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (pop && (i_q_head.cmd == CMD_BOX)) begin
                r_box_valid <= 1'b1;
            end

            // skipped point still closes its frame
            if (pop && (i_q_head.cmd == CMD_POINT) && !launch && i_q_head.last) begin
                r_frame_matched <= 1'b0;
            end else if (cmp_done) begin
                if (r_pt_last) begin
                    r_frame_matched <= 1'b0;
                end else if (hit) begin
                    r_frame_matched <= 1'b1;
                end
            end

            if (pop && (i_q_head.cmd == CMD_COEF)) begin
                for (int i = 0; i < ROWS; i++) begin
                    for (int j = 0; j < COLS; j++) begin
                        if (i_q_head.cidx == COEF_IDX_W'(i*COLS+j)) begin
                            r_coef[i][j] <= i_q_head.cval;
                        end
                    end
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (pop && (i_q_head.cmd == CMD_BOX)) begin
            r_left   <= i_q_head.left;
            r_top    <= i_q_head.top;
            r_width  <= i_q_head.width;
            r_height <= i_q_head.height;
            r_class  <= i_q_head.cls;
        end

        if (launch) begin
            r_pt_x    <= i_q_head.x;
            r_pt_y    <= i_q_head.y;
            r_pt_z    <= i_q_head.z;
            r_pt_last <= i_q_head.last;
            r_bnd[BND_L] <= BND_W'(r_left);
            r_bnd[BND_R] <= BND_W'(r_left) + BND_W'(r_width);
            r_bnd[BND_T] <= BND_W'(r_top) + BND_W'(i_row_bias);
            r_bnd[BND_B] <= BND_W'(r_top) + BND_W'(i_row_bias) + BND_W'(r_height);
            for (int i = 0; i < ROWS; i++) begin
                r_acc[i] <= ACC_W'(r_coef[i][COLS-1]) <<< POINT_FRAC;
            end
        end else if (mac_add) begin
            for (int i = 0; i < ROWS; i++) begin
                r_acc[i] <= r_acc[i] + ACC_W'(r_prod[i]);
            end
        end

        if (mac_mul) begin
            for (int i = 0; i < ROWS; i++) begin
                r_prod[i] <= PROD_W'(r_coef[i][mac_col]) * PROD_W'(mac_coord);
            end
        end

        // c split in halves keeps each multiplier narrow
        if (do_bound) begin
            r_c_pos <= !r_acc[ROWS-1][ACC_W-1] && (r_acc[ROWS-1] != '0);
            for (int j = 0; j < NBND; j++) begin
                r_pp_lo[j] <= PP_W'(r_bnd[j]) * PP_W'(c_lo);
                r_pp_hi[j] <= PP_W'(r_bnd[j]) * PP_W'(c_hi);
            end
        end

        if (load_out) begin
            r_out_data.hit_x     <= r_pt_x;
            r_out_data.hit_y     <= r_pt_y;
            r_out_data.hit_z     <= r_pt_z;
            r_out_data.hit_class <= r_class;
        end
    end

    assign o_q_pop          = pop;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;
    assign o_stat.state     = r_state;
    assign o_stat.box_valid = r_box_valid;

endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpbg_pkg::*;

    // Request code that the block must drop without touching any state
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // One pixel per metre on both axes, c fixed at 1.0: u = x, v = y exactly
    localparam logic signed [COEF_W-1:0] UNIT = 32'sd1048576;

    // Idle time allowed after the last expected hit: a queued point that
    // gives no hit can still be in the back end.
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 300;

    typedef logic signed [95:0] t_wide;

    // How a directed row gets its expected outcome
    typedef enum {BY_MODEL, NO_HIT, TYPED_HIT} t_chk;

    typedef struct {
        t_in_item  item;
        t_chk      how;
        t_out_item res;
    } t_vec;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      cfg_valid = 1'b0;
    logic [BIAS_W-1:0] cfg_data = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;
    logic      cfg_ready;

    // Gate state mirrored on the testbench side
    logic signed [COEF_W-1:0] coef_m    [NCOEF];
    logic signed [COEF_W-1:0] base_coef [NCOEF];  // matrix the current phase runs on
    bit                       box_seen;
    logic [PIXEL_BITS-1:0]    box_l, box_t, box_w, box_h;
    logic [CLASS_W-1:0]       box_cls;
    bit                       frame_hit;
    logic [BIAS_W-1:0]        row_bias_m;

    t_out_item hit_q [$];      // hits still owed by the block, oldest first
    t_vec      plan  [$];      // directed stimulus table
    int        sent_items = 0; // transfers that the block acts on
    int        mismatches = 0;
    bit        tx_calm    = 1'b0;
    bit        rx_calm    = 1'b0;

    lidar_point_bbox_gate u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_gate();
        coef_m     = CALIB;
        base_coef  = CALIB;
        box_seen   = 1'b0;
        box_l      = '0;
        box_t      = '0;
        box_w      = '0;
        box_h      = '0;
        box_cls    = CLASS_UNKNOWN;
        frame_hit  = 1'b0;
        row_bias_m = ROW_BIAS_RESET;
    endtask

    // Homogeneous pixel coordinates, exact (Q.28), no rounding anywhere
    function automatic void project(input t_in_item it, output longint a,
                                    output longint b, output longint c);
        longint x, y, z;
        longint p [NCOEF];
        x = $signed(it.point_x);
        y = $signed(it.point_y);
        z = $signed(it.point_z);
        for (int i = 0; i < NCOEF; i++) p[i] = $signed(coef_m[i]);
        a = p[0] * x + p[1] * y + p[2] * z + p[3] * 256;
        b = p[4] * x + p[5] * y + p[6] * z + p[7] * 256;
        c = p[8] * x + p[9] * y + p[10] * z + p[11] * 256;
    endfunction

    // lo*den <= num <= hi*den, den > 0; needs more than 64 bits
    function automatic bit in_span(longint num, longint den, longint lo, longint hi);
        return (t_wide'(lo) * t_wide'(den) <= t_wide'(num)) &&
               (t_wide'(num) <= t_wide'(hi) * t_wide'(den));
    endfunction

    // Applies one accepted request; returns 1 when it produces a hit
    function automatic bit gate_request(input t_in_item it, output t_out_item res);
        longint a, b, c, row0;
        bit     hit;
        hit = 1'b0;
        res = '0;
        case (it.req_type)
            REQ_BOX: begin
                box_l    = it.box_left;
                box_t    = it.box_top;
                box_w    = it.box_width;
                box_h    = it.box_height;
                box_cls  = (it.sign_class == CLASS_BAD) ? CLASS_UNKNOWN : it.sign_class;
                box_seen = 1'b1;
            end
            REQ_COEF: begin
                if (it.coef_index < NCOEF) coef_m[it.coef_index] = it.coef_value;
            end
            REQ_POINT: begin
                if (box_seen && !frame_hit) begin
                    project(it, a, b, c);
                    row0 = longint'(box_t) + longint'(row_bias_m);
                    if (c > 0 &&
                        in_span(a, c, box_l, longint'(box_l) + longint'(box_w)) &&
                        in_span(b, c, row0, row0 + longint'(box_h))) begin
                        res.hit_x     = it.point_x;
                        res.hit_y     = it.point_y;
                        res.hit_z     = it.point_z;
                        res.hit_class = box_cls;
                        frame_hit     = 1'b1;
                        hit           = 1'b1;
                    end
                end
                if (it.last_point) frame_hit = 1'b0;
            end
            default: ;
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    // Every field random, request code included
    function automatic t_in_item rand_item();
        logic [159:0] w;
        w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return w[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item pt(int x, int y, int z, bit last);
        t_in_item it;
        it            = '0;
        it.req_type   = REQ_POINT;
        it.point_x    = 24'(x);
        it.point_y    = 24'(y);
        it.point_z    = 24'(z);
        it.last_point = last;
        return it;
    endfunction

    function automatic t_in_item bx(int l, int t, int w, int h, int cls);
        t_in_item it;
        it            = '0;
        it.req_type   = REQ_BOX;
        it.box_left   = 11'(l);
        it.box_top    = 11'(t);
        it.box_width  = 11'(w);
        it.box_height = 11'(h);
        it.sign_class = 3'(cls);
        return it;
    endfunction

    function automatic t_in_item cw(int idx, logic signed [COEF_W-1:0] val);
        t_in_item it;
        it            = '0;
        it.req_type   = REQ_COEF;
        it.coef_index = 4'(idx);
        it.coef_value = val;
        return it;
    endfunction

    function automatic t_out_item hit(int x, int y, int z, int cls);
        t_out_item r;
        r.hit_x     = 24'(x);
        r.hit_y     = 24'(y);
        r.hit_z     = 24'(z);
        r.hit_class = 3'(cls);
        return r;
    endfunction

    function automatic int clip(longint v);
        if (v < 0) return 0;
        if (v > 2047) return 2047;
        return int'(v);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // One transfer on the input channel. Entered and left at a falling edge;
    // valid stays high across back-to-back items, so it is never lowered and
    // raised in the same step.
    task automatic send(input t_in_item it, input t_chk how, input t_out_item typed);
        int        gap;
        t_out_item res;
        bit        got;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        got = gate_request(it, res);
        case (how)
            BY_MODEL:  if (got) hit_q.push_back(res);
            TYPED_HIT: hit_q.push_back(typed);
            default: ;
        endcase
        if (it.req_type != REQ_UNUSED) sent_items++;
        @(negedge clk);
    endtask

    // Hold off until every owed hit is out and the back end has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (hit_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // row_bias is only changed with the block idle
    task automatic set_row_bias(input logic [BIAS_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        row_bias_m = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Rewrites all twelve entries: the calibration or the unit-pixel matrix
    task automatic load_matrix(input bit unit);
        for (int i = 0; i < NCOEF; i++) begin
            if (unit) base_coef[i] = (i == 0 || i == 5 || i == 11) ? UNIT : '0;
            else      base_coef[i] = CALIB[i];
            send(cw(i, base_coef[i]), NO_HIT, '0);
        end
    endtask

    // Directed table. Typed outcomes rely on the calibration matrix: a point
    // 10 m straight ahead lands near pixel (328, 275), the origin near
    // (410, 631), and a point far behind has c < 0.
    task automatic load_directed();
        t_in_item junk;
        junk          = bx(2047, 0, 0, 0, 5);
        junk.req_type = REQ_UNUSED;
        // no box yet: nothing, frame closes anyway
        plan.push_back('{pt(2560, 0, 0, 1), NO_HIT, '0});
        plan.push_back('{bx(0, 0, 2047, 2047, 3), NO_HIT, '0});
        plan.push_back('{pt(2560, 0, 0, 0), TYPED_HIT, hit(2560, 0, 0, 3)});
        // frame already matched
        plan.push_back('{pt(2560, 0, 0, 0), NO_HIT, '0});
        // class 7 reads back as unknown; box update keeps the frame matched
        plan.push_back('{bx(0, 0, 2047, 2047, 7), NO_HIT, '0});
        plan.push_back('{pt(2560, 0, 0, 1), NO_HIT, '0});
        plan.push_back('{pt(2560, 0, 0, 1), TYPED_HIT, hit(2560, 0, 0, 0)});
        // behind the camera
        plan.push_back('{pt(-8388608, 0, 0, 0), NO_HIT, '0});
        plan.push_back('{pt(0, 0, 0, 1), TYPED_HIT, hit(0, 0, 0, 0)});
        // unused request code and out-of-range coefficient slot: both dropped,
        // so the full-frame box still catches the next point
        plan.push_back('{junk, NO_HIT, '0});
        plan.push_back('{cw(15, 32'sd0), NO_HIT, '0});
        plan.push_back('{pt(2560, 0, 0, 1), TYPED_HIT, hit(2560, 0, 0, 0)});
        // field extremes
        plan.push_back('{bx(2047, 2047, 2047, 2047, 6), NO_HIT, '0});
        plan.push_back('{pt(8388607, 8388607, 8388607, 0), BY_MODEL, '0});
        plan.push_back('{pt(-8388608, -8388608, -8388608, 0), BY_MODEL, '0});
        plan.push_back('{pt(8388607, -8388608, 0, 1), BY_MODEL, '0});
        plan.push_back('{cw(0, 32'sh80000000), NO_HIT, '0});
        plan.push_back('{cw(11, 32'sh7FFFFFFF), NO_HIT, '0});
        plan.push_back('{bx(0, 0, 2047, 2047, 1), NO_HIT, '0});
        plan.push_back('{pt(8388607, 0, 0, 0), BY_MODEL, '0});
        plan.push_back('{pt(-8388608, 8388607, -8388608, 1), BY_MODEL, '0});
        plan.push_back('{cw(0, CALIB[0]), NO_HIT, '0});
        plan.push_back('{cw(11, CALIB[11]), NO_HIT, '0});
        plan.push_back('{pt(2560, 0, 0, 1), TYPED_HIT, hit(2560, 0, 0, 1)});
    endtask

    // Random frames: a box placed around a chosen target point, then a few
    // points near it, elsewhere, behind the camera or fully random. With the
    // unit matrix the box edges sit on the target's exact pixel, so the
    // equality ends of both range tests get exercised.
    task automatic run_frames(input int upto, input bit unit);
        t_in_item tgt, it;
        longint   a, b, c;
        int       tx, ty, tz, m1, m2, npts, pidx, kind, dx, dy;
        int       steps [6];
        steps = '{-256, -1, 0, 0, 1, 256};
        while (sent_items < upto) begin
            if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
            // stray request of any kind, unused code included
            if ($urandom_range(0, 11) == 0) begin
                send(rand_item(), BY_MODEL, '0);
                continue;
            end
            // occasionally bend one matrix entry for this frame
            pidx = NCOEF;
            if ($urandom_range(0, 9) == 0) begin
                pidx = $urandom_range(0, 15);
                it = rand_item();
                it.req_type   = REQ_COEF;
                it.coef_index = 4'(pidx);
                send(it, BY_MODEL, '0);
            end
            // target point
            if (unit) begin
                tx = $urandom_range(0, 2047) * 256;
                ty = $urandom_range(0, 2047) * 256;
                if ($urandom_range(0, 3) == 0) tx += $urandom_range(0, 255);
                if ($urandom_range(0, 3) == 0) ty += $urandom_range(0, 255);
                tz = $urandom_range(0, 24'hFFFFFF);
            end else begin
                tx = $urandom_range(3 * 256, 60 * 256);
                ty = int'($urandom_range(0, tx)) - tx / 2;
                tz = int'($urandom_range(0, tx / 2)) - tx / 4;
            end
            tgt = pt(tx, ty, tz, 0);
            project(tgt, a, b, c);
            // box around the target pixel, or anywhere
            it = rand_item();
            it.req_type = REQ_BOX;
            if (c > 0 && $urandom_range(0, 5) != 0) begin
                m1 = unit ? $urandom_range(0, 2) : $urandom_range(0, 40);
                m2 = unit ? $urandom_range(0, 2) : $urandom_range(0, 40);
                it.box_left   = 11'(clip(a / c - m1));
                it.box_width  = 11'(clip(m1 + $urandom_range(0, unit ? 2 : 40)));
                it.box_top    = 11'(clip(b / c - longint'(row_bias_m) - m2));
                it.box_height = 11'(clip(m2 + $urandom_range(0, unit ? 2 : 40)));
            end
            send(it, BY_MODEL, '0);
            // points of the frame; some frames run on without a last point
            npts = $urandom_range(1, 8);
            for (int j = 0; j < npts; j++) begin
                it = rand_item();
                it.req_type = REQ_POINT;
                kind = $urandom_range(0, 9);
                if (kind <= 3) begin
                    dx = unit ? steps[$urandom_range(0, 5)] : int'($urandom_range(0, 64)) - 32;
                    dy = unit ? steps[$urandom_range(0, 5)] : int'($urandom_range(0, 64)) - 32;
                    it.point_x = 24'(tx + dx);
                    it.point_y = 24'(ty + dy);
                    if (!unit) it.point_z = 24'(tz + int'($urandom_range(0, 64)) - 32);
                end else if (kind <= 7) begin
                    if (unit) begin
                        it.point_x = 24'($urandom_range(0, 2047 * 256));
                        it.point_y = 24'($urandom_range(0, 2047 * 256));
                    end else begin
                        dx = $urandom_range(256, 80 * 256);
                        it.point_x = 24'(dx);
                        it.point_y = 24'(int'($urandom_range(0, dx)) - dx / 2);
                        it.point_z = 24'(int'($urandom_range(0, dx / 2)) - dx / 4);
                    end
                end else if (kind == 8) begin
                    it.point_x = 24'(-int'($urandom_range(0, 60 * 256)));
                end
                it.last_point = (j == npts - 1) && ($urandom_range(0, 7) != 0);
                send(it, BY_MODEL, '0);
            end
            if (pidx < NCOEF) send(cw(pidx, base_coef[pidx]), BY_MODEL, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        logic [BIAS_W-1:0] bias;
        reset_gate();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed part runs on the reset value of row_bias
        load_directed();
        foreach (plan[i]) send(plan[i].item, plan[i].how, plan[i].res);

        // random phases: bias extremes first, then the unit matrix, then back
        // to the calibration with other bias settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       bias = 8'd0;
                1:       bias = 8'd255;
                4:       bias = ROW_BIAS_RESET;
                default: bias = 8'($urandom_range(1, 254));
            endcase
            set_row_bias(bias);
            if (ph == 2) load_matrix(1'b1);
            if (ph == 3) load_matrix(1'b0);
            run_frames(sent_items + PHASE_ITEMS, ph == 2);
        end

        drain();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Ready may drop before each result, with calm stretches
    initial begin : rx
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Every output transfer is matched against the oldest owed hit
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (hit_q.size() == 0) begin
                $error("hit with none owed: x=%0d y=%0d z=%0d class=%0d",
                       out_data.hit_x, out_data.hit_y, out_data.hit_z,
                       out_data.hit_class);
                mismatches++;
            end else begin
                want = hit_q.pop_front();
                if (out_data.hit_x !== want.hit_x) begin
                    $error("hit_x expected %0d got %0d", want.hit_x, out_data.hit_x);
                    mismatches++;
                end
                if (out_data.hit_y !== want.hit_y) begin
                    $error("hit_y expected %0d got %0d", want.hit_y, out_data.hit_y);
                    mismatches++;
                end
                if (out_data.hit_z !== want.hit_z) begin
                    $error("hit_z expected %0d got %0d", want.hit_z, out_data.hit_z);
                    mismatches++;
                end
                if (out_data.hit_class !== want.hit_class) begin
                    $error("hit_class expected %0d got %0d",
                           want.hit_class, out_data.hit_class);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: the slowest legal run is far below this
    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
